// ===== design/assert_macros.svh =====
// Assertion macros shared by the memory mapped data bus RTL.
// Both macros assume a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MMDB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define MMDB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/mmdb_pkg.sv =====
// Package for the memory mapped data bus: codes, sizes and the request structs.
// No dependencies.
`timescale 1ns / 1ps

package mmdb_pkg;

  localparam int RAM_SIZE  = 32768;
  localparam int TERM_SIZE = 512;
  localparam int RAM_WORDS = RAM_SIZE / 4;
  localparam int RAM_AW    = $clog2(RAM_WORDS);

  localparam int OFF_W   = 16;
  localparam int TOFF_W  = 9;
  localparam int DATA_W  = 32;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  localparam logic [3:0] REGION_RAM  = 4'h8;
  localparam logic [3:0] REGION_TERM = 4'h9;

  localparam logic [OFF_W:0] LIM_BYTE = (OFF_W + 1)'(RAM_SIZE - 1);
  localparam logic [OFF_W:0] LIM_HALF = (OFF_W + 1)'(RAM_SIZE - 2);
  localparam logic [OFF_W:0] LIM_WORD = (OFF_W + 1)'(RAM_SIZE - 4);
  localparam logic [OFF_W:0] LIM_TERM = (OFF_W + 1)'(TERM_SIZE);

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [3:0]        be;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic              ram_rd;
    logic [1:0]        size;
    logic [1:0]        lane;
    logic [DATA_W-1:0] fixed_data;
    logic              range_error;
    logic              slave_error;
    logic              term_valid;
    logic [TOFF_W-1:0] term_offset;
    logic [7:0]        term_data;
  } resp_t;

endpackage

// ===== design/memory_mapped_data_bus.sv =====
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is not stalled, set by the single RAM port that serves
// each read or byte-enabled write in one access.
// Reset clears the output valid only; RAM contents are undefined until written.
// Top level of the memory mapped data bus; depends on mmdb_pkg, mmdb_decode,
// mmdb_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module memory_mapped_data_bus
  import mmdb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [1:0]        in_access_size,
  input  logic [31:0]       in_address,
  input  logic [DATA_W-1:0] in_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic              out_range_error,
  output logic              out_slave_error,
  output logic              out_term_valid,
  output logic [TOFF_W-1:0] out_term_offset,
  output logic [7:0]        out_term_data
);

  ram_req_t          ram_req;
  resp_t             resp;
  resp_t             resp_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              accept;
  logic [DATA_W-1:0] ram_q;
  logic [DATA_W-1:0] shifted;

  mmdb_decode u_decode (
    .cmd         (in_cmd),
    .access_size (in_access_size),
    .address     (in_address),
    .write_data  (in_write_data),
    .ram_req     (ram_req),
    .resp        (resp)
  );

  mmdb_ram #(
    .DEPTH (RAM_WORDS),
    .AW    (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .en    (accept && ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .be    (ram_req.be),
    .wdata (ram_req.wdata),
    .rdata (ram_q)
  );

  assign in_stall      = out_valid_r && out_stall;
  assign accept        = in_valid && !in_stall;
  assign out_valid_nxt = accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_r <= resp;
    end
  end

  always_comb begin
    shifted = ram_q >> {resp_r.lane, 3'b000};
    if (resp_r.ram_rd) begin
      unique case (resp_r.size)
        SIZE_BYTE: out_read_data = {24'd0, shifted[7:0]};
        SIZE_HALF: out_read_data = {16'd0, shifted[15:0]};
        default:   out_read_data = ram_q;
      endcase
    end else begin
      out_read_data = resp_r.fixed_data;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_error = resp_r.range_error;
  assign out_slave_error = resp_r.slave_error;
  assign out_term_valid  = resp_r.term_valid;
  assign out_term_offset = resp_r.term_offset;
  assign out_term_data   = resp_r.term_data;

  `MMDB_ASSERT_NEXT(a_accept_gives_result, in_valid && !in_stall, out_valid)
  `MMDB_ASSERT_IMPL(a_full_blocks_input, out_valid && out_stall, in_stall)
  `MMDB_ASSERT_IMPL(a_term_write_no_data, out_valid && out_term_valid, out_read_data == '0)
  `MMDB_ASSERT_IMPL(a_slave_no_range, out_valid && out_slave_error, !out_range_error)

endmodule

// ===== design/mmdb_ram.sv =====
// Byte-lane synchronous RAM with one read/write port and registered read data.
// Generic; no package dependencies.
`timescale 1ns / 1ps

module mmdb_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [3:0]    be,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [3:0][7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        for (int i = 0; i < 4; i++) begin
          if (be[i]) begin
            mem[addr][i] <= wdata[8*i +: 8];
          end
        end
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== design/mmdb_decode.sv =====
// Request decoder: region select, range checks, RAM lane enables and response fields.
// Depends on mmdb_pkg.
`timescale 1ns / 1ps

module mmdb_decode
  import mmdb_pkg::*;
(
  input  logic              cmd,
  input  logic [1:0]        access_size,
  input  logic [31:0]       address,
  input  logic [DATA_W-1:0] write_data,
  output ram_req_t          ram_req,
  output resp_t             resp
);

  logic [3:0]       region;
  logic [OFF_W:0]   off;
  logic             ram_hit;
  logic             term_hit;
  logic             ram_err;
  logic [OFF_W-1:0] ram_off;
  logic [OFF_W:0]   toff_full;
  logic             term_err;
  logic [OFF_W-1:0] term_off;
  logic [OFF_W-1:0] acc_off;
  logic [3:0]       be;
  logic [DATA_W-1:0] wdata_lanes;

  always_comb begin
    region   = address[31:28];
    off      = {1'b0, address[OFF_W-1:0]};
    ram_hit  = (region == REGION_RAM) && (access_size != SIZE_BAD);
    term_hit = (region == REGION_TERM) && (access_size == SIZE_BYTE);

    unique case (access_size)
      SIZE_BYTE: ram_err = off > LIM_BYTE;
      SIZE_HALF: ram_err = off > LIM_HALF;
      default:   ram_err = off > LIM_WORD;
    endcase
    ram_off = ram_err ? '0 : off[OFF_W-1:0];
    unique case (access_size)
      SIZE_HALF: ram_off[0] = 1'b0;
      SIZE_WORD: ram_off[1:0] = 2'b00;
      default:   ram_off = ram_off;
    endcase

    toff_full = (cmd == CMD_WRITE) ? off : {2'b00, address[14:0]};
    term_err  = toff_full >= LIM_TERM;
    term_off  = term_err ? '0 : toff_full[OFF_W-1:0];

    acc_off = term_hit ? term_off : ram_off;

    unique case (access_size)
      SIZE_BYTE: begin
        be          = 4'b0001 << acc_off[1:0];
        wdata_lanes = {4{write_data[7:0]}};
      end
      SIZE_HALF: begin
        be          = acc_off[1] ? 4'b1100 : 4'b0011;
        wdata_lanes = {2{write_data[15:0]}};
      end
      default: begin
        be          = 4'b1111;
        wdata_lanes = write_data;
      end
    endcase

    ram_req.en    = ram_hit || (term_hit && (cmd == CMD_READ));
    ram_req.we    = ram_hit && (cmd == CMD_WRITE);
    ram_req.addr  = acc_off[RAM_AW+1:2];
    ram_req.be    = be;
    ram_req.wdata = wdata_lanes;

    resp.ram_rd      = (ram_hit || term_hit) && (cmd == CMD_READ);
    resp.size        = access_size;
    resp.lane        = acc_off[1:0];
    resp.range_error = (ram_hit && ram_err) || (term_hit && term_err);
    resp.slave_error = !(ram_hit || term_hit);
    resp.term_valid  = term_hit && (cmd == CMD_WRITE);
    resp.term_offset = resp.term_valid ? term_off[TOFF_W-1:0] : '0;
    resp.term_data   = resp.term_valid ? write_data[7:0] : '0;

    if (resp.slave_error && (cmd == CMD_READ)) begin
      unique case (access_size)
        SIZE_BYTE: resp.fixed_data = 32'h0000_00FF;
        SIZE_HALF: resp.fixed_data = 32'h0000_FFFF;
        default:   resp.fixed_data = 32'hFFFF_FFFF;
      endcase
    end else begin
      resp.fixed_data = '0;
    end
  end

endmodule
